### rtl/core/gsr_pkg.sv
// Shared types and constants for the Gaussian spot renderer.
// No dependencies; imported by every module of the block.
package gsr_pkg;

    // Field and register widths
    localparam int PIX_W     = 8;
    localparam int COORD_W   = 8;
    localparam int INV_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Scaled offset (Q8.16), its square (Q16.32) and the rounded sum (Q3.12)
    localparam int SCALED_W  = COORD_W + INV_W;
    localparam int SQUARE_W  = 2 * SCALED_W;
    localparam int QSUM_W    = SQUARE_W + 2;
    localparam int SUM_SHIFT = 20;
    localparam int SUM_W     = 15;
    localparam int SEG_BITS  = 9;
    localparam int IDX_W     = SUM_W - SEG_BITS;
    localparam int TAB_IDX_W = IDX_W + 1;
    localparam int TAB_W     = 16;
    localparam int PROD_W    = TAB_W + SEG_BITS;

    // Pipeline depth
    localparam int NUM_STAGES = 7;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_INV_SIGMA_X = 3'd2,
        CFG_INV_SIGMA_Y = 3'd3,
        CFG_MIN_LEVEL   = 3'd4
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [COORD_W-1:0] RST_CENTER_X  = 8'd128;
    localparam logic [COORD_W-1:0] RST_CENTER_Y  = 8'd128;
    localparam logic [INV_W-1:0]   RST_INV_SIGMA = 16'd6554;
    localparam logic [PIX_W-1:0]   RST_MIN_LEVEL = 8'd10;

    // Per-pixel data that rides along the pipeline untouched
    typedef struct packed {
        logic [PIX_W-1:0] old_pixel;
        logic             in_range;
    } side_t;

    // 255*exp(-k/8) in Q8.8 for k = 0..64
    localparam logic [TAB_W-1:0] EXP_TAB [0:64] = '{
        16'd65280, 16'd57609, 16'd50840, 16'd44866, 16'd39594, 16'd34942, 16'd30836,
        16'd27213, 16'd24015, 16'd21193, 16'd18703, 16'd16505, 16'd14566, 16'd12854,
        16'd11344, 16'd10011, 16'd8835,  16'd7797,  16'd6880,  16'd6072,  16'd5359,
        16'd4729,  16'd4173,  16'd3683,  16'd3250,  16'd2868,  16'd2531,  16'd2234,
        16'd1971,  16'd1740,  16'd1535,  16'd1355,  16'd1196,  16'd1055,  16'd931,
        16'd822,   16'd725,   16'd640,   16'd565,   16'd498,   16'd440,   16'd388,
        16'd343,   16'd302,   16'd267,   16'd235,   16'd208,   16'd183,   16'd162,
        16'd143,   16'd126,   16'd111,   16'd98,    16'd87,    16'd76,    16'd67,
        16'd60,    16'd53,    16'd46,    16'd41,    16'd36,    16'd32,    16'd28,
        16'd25,    16'd22
    };

endpackage

### rtl/core/gsr_offset.sv
// Stages 1-2: distance from the spot center and scaling by 1/sigma.
// Depends on gsr_pkg.
module gsr_offset
    import gsr_pkg::*;
(
    input  logic                aclk,
    input  logic [1:0]          load,
    input  logic [COORD_W-1:0]  pixel_row,
    input  logic [COORD_W-1:0]  pixel_col,
    input  side_t               side_in,
    input  logic [COORD_W-1:0]  center_x,
    input  logic [COORD_W-1:0]  center_y,
    input  logic [INV_W-1:0]    inv_sigma_x,
    input  logic [INV_W-1:0]    inv_sigma_y,
    output logic [SCALED_W-1:0] ax,
    output logic [SCALED_W-1:0] ay,
    output side_t               side_out
);

    logic [COORD_W-1:0]  dx_reg, dx_next;
    logic [COORD_W-1:0]  dy_reg, dy_next;
    side_t               side1_reg;
    logic [SCALED_W-1:0] ax_reg, ax_next;
    logic [SCALED_W-1:0] ay_reg, ay_next;
    side_t               side2_reg;

    // Absolute distance on each axis
    always_comb begin
        dx_next = (pixel_col >= center_x) ? (pixel_col - center_x) : (center_x - pixel_col);
        dy_next = (pixel_row >= center_y) ? (pixel_row - center_y) : (center_y - pixel_row);
    end

    // Scale by the reciprocal spreads, exact Q8.16
    always_comb begin
        ax_next = SCALED_W'(dx_reg) * SCALED_W'(inv_sigma_x);
        ay_next = SCALED_W'(dy_reg) * SCALED_W'(inv_sigma_y);
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            side1_reg <= side_in;
        end
        if (load[1]) begin
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            side2_reg <= side1_reg;
        end
    end

    assign ax       = ax_reg;
    assign ay       = ay_reg;
    assign side_out = side2_reg;

endmodule

### rtl/core/gsr_square.sv
// Stages 3-4: squares of the scaled offsets, rounded Q3.12 sum with saturation.
// Depends on gsr_pkg.
module gsr_square
    import gsr_pkg::*;
(
    input  logic                aclk,
    input  logic [1:0]          load,
    input  logic [SCALED_W-1:0] ax,
    input  logic [SCALED_W-1:0] ay,
    input  side_t               side_in,
    output logic [SUM_W-1:0]    sum,
    output logic                sat,
    output side_t               side_out
);

    localparam logic [QSUM_W-1:0] ROUND_HALF = QSUM_W'(1) << (SUM_SHIFT - 1);

    logic [SQUARE_W-1:0] sqx_reg, sqx_next;
    logic [SQUARE_W-1:0] sqy_reg, sqy_next;
    side_t               side3_reg;
    logic [QSUM_W-1:0]   qsum;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                sat_reg, sat_next;
    side_t               side4_reg;

    // Square each scaled offset
    always_comb begin
        sqx_next = SQUARE_W'(ax) * SQUARE_W'(ax);
        sqy_next = SQUARE_W'(ay) * SQUARE_W'(ay);
    end

    // Add, round half up to Q3.12, flag anything at or above 8.0
    always_comb begin
        qsum     = QSUM_W'(sqx_reg) + QSUM_W'(sqy_reg) + ROUND_HALF;
        sum_next = qsum[SUM_SHIFT +: SUM_W];
        sat_next = |qsum[QSUM_W-1:SUM_SHIFT+SUM_W];
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            side3_reg <= side_in;
        end
        if (load[1]) begin
            sum_reg   <= sum_next;
            sat_reg   <= sat_next;
            side4_reg <= side3_reg;
        end
    end

    assign sum      = sum_reg;
    assign sat      = sat_reg;
    assign side_out = side4_reg;

endmodule

### rtl/core/gsr_level.sv
// Stages 5-7: exp table lookup, linear interpolation, threshold and output register.
// Depends on gsr_pkg.
module gsr_level
    import gsr_pkg::*;
(
    input  logic             aclk,
    input  logic [2:0]       load,
    input  logic [SUM_W-1:0] sum,
    input  logic             sat,
    input  side_t            side_in,
    input  logic [PIX_W-1:0] min_level,
    output logic [PIX_W-1:0] new_pixel,
    output logic             overwritten
);

    localparam logic [PROD_W:0] LEVEL_HALF = (PROD_W + 1)'(1) << (PROD_W - SEG_BITS);

    logic [TAB_IDX_W-1:0] idx;
    logic [TAB_W-1:0]     hi5_reg, hi5_next;
    logic [TAB_W-1:0]     diff5_reg, diff5_next;
    logic [SEG_BITS-1:0]  frac5_reg;
    logic                 sat5_reg;
    side_t                side5_reg;
    logic [TAB_W-1:0]     hi6_reg;
    logic [PROD_W-1:0]    prod6_reg, prod6_next;
    logic                 sat6_reg;
    side_t                side6_reg;
    logic [PROD_W:0]      interp;
    logic [PIX_W-1:0]     level;
    logic                 draw;
    logic [PIX_W-1:0]     pix_reg, pix_next;
    logic                 ovw_reg, ovw_next;

    // Look up the segment end points
    always_comb begin
        idx        = TAB_IDX_W'(sum[SUM_W-1:SEG_BITS]);
        hi5_next   = EXP_TAB[idx];
        diff5_next = EXP_TAB[idx] - EXP_TAB[idx + TAB_IDX_W'(1)];
    end

    // Slope times position within the segment
    assign prod6_next = PROD_W'(diff5_reg) * PROD_W'(frac5_reg);

    // Interpolate, round to 8 bits, compare against the threshold
    always_comb begin
        interp   = ((PROD_W + 1)'(hi6_reg) << SEG_BITS) - (PROD_W + 1)'(prod6_reg) + LEVEL_HALF;
        level    = sat6_reg ? '0 : interp[PROD_W-1 -: PIX_W];
        draw     = side6_reg.in_range && (level > min_level);
        pix_next = draw ? level : side6_reg.old_pixel;
        ovw_next = draw;
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            hi5_reg   <= hi5_next;
            diff5_reg <= diff5_next;
            frac5_reg <= sum[SEG_BITS-1:0];
            sat5_reg  <= sat;
            side5_reg <= side_in;
        end
        if (load[1]) begin
            hi6_reg   <= hi5_reg;
            prod6_reg <= prod6_next;
            sat6_reg  <= sat5_reg;
            side6_reg <= side5_reg;
        end
        if (load[2]) begin
            pix_reg <= pix_next;
            ovw_reg <= ovw_next;
        end
    end

    assign new_pixel   = pix_reg;
    assign overwritten = ovw_reg;

endmodule

### rtl/core/gaussian_spot_render_top.sv
// Gaussian spot renderer: replaces a pixel by 255*exp(-a*a-b*b) when above min_level.
// Pipeline: 7 register stages, the first loaded by the input transfer.
// Throughput: one pixel per cycle; a full stage holds only while the stage below holds.
// Reset (aresetn low, synchronous): pipeline emptied, configuration to defaults.
// Depends on gsr_pkg, gsr_offset, gsr_square, gsr_level.
module gaussian_spot_render_top
    import gsr_pkg::*;
#(
    parameter int IMAGE_ROWS = 256,
    parameter int IMAGE_COLS = 256
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    // Pixel input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // pixel_row[7:0], pixel_col[15:8], old_pixel[23:16]
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // new_pixel[7:0]
    output logic [0:0]           m_tuser    // overwritten[0]
);

    logic [COORD_W-1:0]    center_x_reg;
    logic [COORD_W-1:0]    center_y_reg;
    logic [INV_W-1:0]      inv_sigma_x_reg;
    logic [INV_W-1:0]      inv_sigma_y_reg;
    logic [PIX_W-1:0]      min_level_reg;

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] stage_rdy;

    logic [COORD_W-1:0]    pixel_row;
    logic [COORD_W-1:0]    pixel_col;
    side_t                 side_in;
    logic [SCALED_W-1:0]   ax;
    logic [SCALED_W-1:0]   ay;
    side_t                 side_off;
    logic [SUM_W-1:0]      sum;
    logic                  sat;
    side_t                 side_sq;
    logic [PIX_W-1:0]      new_pixel;
    logic                  overwritten;

    // Unpack the input transfer
    always_comb begin
        pixel_row          = s_tdata[7:0];
        pixel_col          = s_tdata[15:8];
        side_in.old_pixel  = s_tdata[23:16];
        side_in.in_range   = (32'(pixel_row) < IMAGE_ROWS) && (32'(pixel_col) < IMAGE_COLS);
    end

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg    <= RST_CENTER_X;
            center_y_reg    <= RST_CENTER_Y;
            inv_sigma_x_reg <= RST_INV_SIGMA;
            inv_sigma_y_reg <= RST_INV_SIGMA;
            min_level_reg   <= RST_MIN_LEVEL;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CENTER_X:    center_x_reg    <= cfg_wdata[COORD_W-1:0];
                CFG_CENTER_Y:    center_y_reg    <= cfg_wdata[COORD_W-1:0];
                CFG_INV_SIGMA_X: inv_sigma_x_reg <= cfg_wdata[INV_W-1:0];
                CFG_INV_SIGMA_Y: inv_sigma_y_reg <= cfg_wdata[INV_W-1:0];
                CFG_MIN_LEVEL:   min_level_reg   <= cfg_wdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or the stage below takes its item
    always_comb begin
        stage_rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_rdy[k] = !vld_reg[k] || stage_rdy[k+1];
        end
    end

    // Advance valid bits alongside the data
    always_comb begin
        vld_next[0] = stage_rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            vld_next[k] = stage_rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    gsr_offset u_offset (
        .aclk        (aclk),
        .load        (stage_rdy[1:0]),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .side_in     (side_in),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .inv_sigma_x (inv_sigma_x_reg),
        .inv_sigma_y (inv_sigma_y_reg),
        .ax          (ax),
        .ay          (ay),
        .side_out    (side_off)
    );

    gsr_square u_square (
        .aclk     (aclk),
        .load     (stage_rdy[3:2]),
        .ax       (ax),
        .ay       (ay),
        .side_in  (side_off),
        .sum      (sum),
        .sat      (sat),
        .side_out (side_sq)
    );

    gsr_level u_level (
        .aclk        (aclk),
        .load        (stage_rdy[6:4]),
        .sum         (sum),
        .sat         (sat),
        .side_in     (side_sq),
        .min_level   (min_level_reg),
        .new_pixel   (new_pixel),
        .overwritten (overwritten)
    );

    assign s_tready = stage_rdy[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = new_pixel;
    assign m_tuser  = overwritten;

endmodule

### rtl/core/gsr_checker.sv
// Port-level checks for gaussian_spot_render_top, bound to the top level.
// Depends on gsr_pkg for widths.
module gsr_checker
    import gsr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [7:0]           m_tdata,
    input logic [0:0]           m_tuser
);

    // Hold a stalled result transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Empty the pipeline on reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input back-pressure only comes from a stalled full output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output can drain");

    // A drawn level always exceeds a threshold of at least zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata != 8'd0)
        else $error("overwrite with zero level");

endmodule

bind gaussian_spot_render_top gsr_checker u_gsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
